>>> hw/rtl/smc_pkg.sv
// smc_pkg: shared types, constants and helper functions of the system mode controller
// used by every module of the controller except smc_fifo; depends on nothing else
package smc_pkg;

    // payload and register widths
    localparam int MODE_W       = 3;
    localparam int MASK_W       = 32;
    localparam int TIME_OUT_W   = 24;
    localparam int CFG_W        = 24;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = 2;

    // default configuration of the design
    localparam int TICK_COUNTER_BITS_DEF = 24;
    localparam int CMD_FIFO_DEPTH        = 2;
    localparam int RES_FIFO_DEPTH        = 4;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_TRIAGE_TIMEOUT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ERROR_TIMEOUT  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAME_TIMEOUT   = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] TRIAGE_TIMEOUT_RST = 24'd30000;
    localparam logic [CFG_W-1:0] ERROR_TIMEOUT_RST  = 24'd10000;
    localparam logic [CFG_W-1:0] GAME_TIMEOUT_RST   = 24'd300000;

    // mode codes, the two highest codes are invalid
    localparam logic [MODE_W-1:0] MODE_BOOTING   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TRIAGE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CONNECTED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GAME      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ERROR     = 3'd5;

    // feature bits owned by the mode
    localparam logic [MASK_W-1:0] CTRL_BITS        = 32'h0000_00F6;
    localparam logic [MASK_W-1:0] BITS_IDLE        = 32'h0000_0006;
    localparam logic [MASK_W-1:0] BITS_TRIAGE      = 32'h0000_00E6;
    localparam logic [MASK_W-1:0] BITS_CONNECTED   = 32'h0000_00F6;
    localparam logic [MASK_W-1:0] BITS_GAME        = 32'h0000_00F6;
    localparam logic [MASK_W-1:0] BITS_ERROR       = 32'h0000_0006;

    localparam logic [TIME_OUT_W-1:0] TIME_OUT_MAX = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_REQUEST   = 2'd1,
        KIND_PEER_GAME = 2'd2,
        KIND_ACTIVITY  = 2'd3
    } item_kind_t;

    typedef enum logic [1:0] {
        CAUSE_REQUEST = 2'd0,
        CAUSE_TRIAGE  = 2'd1,
        CAUSE_ERROR   = 2'd2,
        CAUSE_GAME    = 2'd3
    } cause_t;

    // step of the peer game chain
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] triage_timeout;
        logic [CFG_W-1:0] error_timeout;
        logic [CFG_W-1:0] game_timeout;
    } cfg_t;

    typedef struct packed {
        item_kind_t        kind;
        logic [MODE_W-1:0] target;
        logic [MASK_W-1:0] mask;
    } cmd_t;

    typedef struct packed {
        logic                  accepted;
        logic                  changed;
        logic [MODE_W-1:0]     from_mode;
        logic [MODE_W-1:0]     to_mode;
        cause_t                cause;
        logic [MASK_W-1:0]     mask;
        logic [TIME_OUT_W-1:0] time_in_mode;
        logic                  last;
    } result_t;

    // allowed transition table
    function automatic logic allowed(input logic [MODE_W-1:0] from, input logic [MODE_W-1:0] to);
        logic ok;
        ok = 1'b0;
        if (to == MODE_ERROR || to == MODE_IDLE)
        begin
            ok = 1'b1;
        end
        else
        begin
            unique case (from)
                MODE_IDLE:      ok = (to == MODE_TRIAGE) || (to == MODE_CONNECTED) ||
                                     (to == MODE_GAME);
                MODE_TRIAGE:    ok = (to == MODE_CONNECTED);
                MODE_CONNECTED: ok = (to == MODE_TRIAGE) || (to == MODE_GAME);
                MODE_GAME:      ok = (to == MODE_CONNECTED);
                default:        ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    // feature bits that a mode turns on
    function automatic logic [MASK_W-1:0] mode_bits(input logic [MODE_W-1:0] m);
        logic [MASK_W-1:0] bits;
        unique case (m)
            MODE_IDLE:      bits = BITS_IDLE;
            MODE_TRIAGE:    bits = BITS_TRIAGE;
            MODE_CONNECTED: bits = BITS_CONNECTED;
            MODE_GAME:      bits = BITS_GAME;
            MODE_ERROR:     bits = BITS_ERROR;
            default:        bits = '0;
        endcase
        return bits;
    endfunction

    // mode-owned bits from the new mode, the rest passes through
    function automatic logic [MASK_W-1:0] merge_mask(input logic [MASK_W-1:0] mask,
                                                     input logic [MODE_W-1:0] m);
        return (mask & ~CTRL_BITS) | (mode_bits(m) & CTRL_BITS);
    endfunction

endpackage

>>> hw/rtl/smc_fifo.sv
// smc_fifo: small first-word-fall-through queue of register slots
// generic over width and depth; depends on nothing else
module smc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/smc_regs.sv
// smc_regs: APB-style configuration registers holding the three timeouts
// depends on smc_pkg
module smc_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [smc_pkg::PADDR_W-1:0]  paddr,
    input  logic [smc_pkg::PDATA_W-1:0]  pwdata,
    output logic [smc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output smc_pkg::cfg_t                cfg
);

    smc_pkg::cfg_t                  cfg_reg, cfg_next;
    logic [smc_pkg::REG_IDX_W-1:0]  idx;
    logic                           wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[smc_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                smc_pkg::REG_TRIAGE_TIMEOUT:
                    cfg_next.triage_timeout = pwdata[smc_pkg::CFG_W-1:0];
                smc_pkg::REG_ERROR_TIMEOUT:
                    cfg_next.error_timeout = pwdata[smc_pkg::CFG_W-1:0];
                smc_pkg::REG_GAME_TIMEOUT:
                    cfg_next.game_timeout = pwdata[smc_pkg::CFG_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            smc_pkg::REG_TRIAGE_TIMEOUT:
                prdata = smc_pkg::PDATA_W'(cfg_reg.triage_timeout);
            smc_pkg::REG_ERROR_TIMEOUT:
                prdata = smc_pkg::PDATA_W'(cfg_reg.error_timeout);
            smc_pkg::REG_GAME_TIMEOUT:
                prdata = smc_pkg::PDATA_W'(cfg_reg.game_timeout);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.triage_timeout <= smc_pkg::TRIAGE_TIMEOUT_RST;
            cfg_reg.error_timeout  <= smc_pkg::ERROR_TIMEOUT_RST;
            cfg_reg.game_timeout   <= smc_pkg::GAME_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/smc_front.sv
// smc_front: accepts input transactions, classifies them into commands and queues them
// depends on smc_pkg and smc_fifo
module smc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  mode,
    input  logic [smc_pkg::MODE_W-1:0]  target_mode,
    input  logic [smc_pkg::MASK_W-1:0]  feature_mask_in,
    output logic                        cmd_valid,
    output smc_pkg::cmd_t               cmd,
    input  logic                        cmd_pop
);

    smc_pkg::cmd_t cmd_in;
    logic          cmd_empty;

    // classify the transaction; a transition request carries its target, a peer game request targets game mode
    always_comb
    begin
        cmd_in.kind = smc_pkg::item_kind_t'(mode);
        cmd_in.mask = feature_mask_in;
        unique case (cmd_in.kind)
            smc_pkg::KIND_REQUEST:   cmd_in.target = target_mode;
            smc_pkg::KIND_PEER_GAME: cmd_in.target = smc_pkg::MODE_GAME;
            default:                 cmd_in.target = '0;
        endcase
    end

    // command queue between front and back
    smc_fifo #(
        .WIDTH ($bits(smc_pkg::cmd_t)),
        .DEPTH (smc_pkg::CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd),
        .full    (full),
        .empty   (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

>>> hw/rtl/smc_back.sv
// smc_back: executes queued commands, one mode step per cycle while the result queue is not full, and emits results
// depends on smc_pkg
module smc_back #(
    parameter int TICK_COUNTER_BITS = smc_pkg::TICK_COUNTER_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  smc_pkg::cfg_t    cfg,
    input  logic             cmd_valid,
    input  smc_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    input  logic             res_full,
    output logic             res_push,
    output smc_pkg::result_t res
);

    localparam int TB = TICK_COUNTER_BITS;
    localparam int CW = (TB > smc_pkg::CFG_W) ? TB : smc_pkg::CFG_W;
    localparam logic [TB-1:0] CNT_MAX = {TB{1'b1}};

    logic [smc_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [smc_pkg::MODE_W-1:0] origin_reg, origin_next;
    logic [TB-1:0]              tim_reg, tim_next;
    logic [TB-1:0]              tsa_reg, tsa_next;
    logic [smc_pkg::MASK_W-1:0] mask_reg, mask_next;
    smc_pkg::phase_t            phase_reg, phase_next;

    logic                       step;
    logic [TB-1:0]              tim_inc;
    logic [TB-1:0]              tsa_inc;
    logic [TB-1:0]              tim_base;
    logic [TB-1:0]              tsa_base;
    logic [CW-1:0]              tim_cmp;
    logic [CW-1:0]              tsa_cmp;
    logic [CW-1:0]              tim_sat_cmp;
    logic [smc_pkg::MODE_W-1:0] tgt;
    smc_pkg::cause_t            cause_v;
    logic                       try_chg;
    logic                       force_fail;
    logic                       ok;
    logic                       is_peer;
    logic                       last_v;
    logic [smc_pkg::MASK_W-1:0] mask_base;

    assign step     = cmd_valid && !res_full;
    assign tim_inc  = (tim_reg == CNT_MAX) ? tim_reg : tim_reg + 1'b1;
    assign tsa_inc  = (tsa_reg == CNT_MAX) ? tsa_reg : tsa_reg + 1'b1;
    assign tim_cmp  = CW'(tim_inc);
    assign tsa_cmp  = CW'(tsa_inc);
    assign is_peer  = (cmd.kind == smc_pkg::KIND_PEER_GAME);
    assign mask_base = (phase_reg == smc_pkg::PH_FIRST) ? cmd.mask : mask_reg;

    // decode of one step: target, cause and whether a change is tried
    always_comb
    begin
        tgt        = mode_reg;
        cause_v    = smc_pkg::CAUSE_REQUEST;
        try_chg    = 1'b0;
        force_fail = 1'b0;
        tim_base   = tim_reg;
        tsa_base   = tsa_reg;
        unique case (cmd.kind)
            smc_pkg::KIND_TICK:
            begin
                tim_base = tim_inc;
                tsa_base = tsa_inc;
                priority if (mode_reg == smc_pkg::MODE_TRIAGE &&
                             tsa_cmp > CW'(cfg.triage_timeout))
                begin
                    tgt     = smc_pkg::MODE_IDLE;
                    cause_v = smc_pkg::CAUSE_TRIAGE;
                end
                else if (mode_reg == smc_pkg::MODE_ERROR &&
                         tim_cmp > CW'(cfg.error_timeout))
                begin
                    tgt     = smc_pkg::MODE_IDLE;
                    cause_v = smc_pkg::CAUSE_ERROR;
                end
                else if (mode_reg == smc_pkg::MODE_GAME &&
                         tim_cmp > CW'(cfg.game_timeout))
                begin
                    tgt     = origin_reg;
                    cause_v = smc_pkg::CAUSE_GAME;
                end
                else
                begin
                    tgt = mode_reg;
                end
                if (tgt == mode_reg)
                begin
                    cause_v = smc_pkg::CAUSE_REQUEST;
                end
                try_chg = (tgt != mode_reg);
            end
            smc_pkg::KIND_REQUEST:
            begin
                tgt     = cmd.target;
                try_chg = (cmd.target != mode_reg);
            end
            smc_pkg::KIND_PEER_GAME:
            begin
                priority if (phase_reg == smc_pkg::PH_FIRST && mode_reg == smc_pkg::MODE_GAME)
                begin
                    tgt = mode_reg;
                end
                else if (phase_reg == smc_pkg::PH_FIRST &&
                         (mode_reg == smc_pkg::MODE_BOOTING || mode_reg == smc_pkg::MODE_ERROR))
                begin
                    tgt     = smc_pkg::MODE_IDLE;
                    try_chg = 1'b1;
                end
                else if (phase_reg != smc_pkg::PH_THIRD &&
                         (mode_reg == smc_pkg::MODE_IDLE || mode_reg == smc_pkg::MODE_TRIAGE))
                begin
                    tgt     = smc_pkg::MODE_CONNECTED;
                    try_chg = 1'b1;
                end
                else if (mode_reg == smc_pkg::MODE_CONNECTED)
                begin
                    tgt     = smc_pkg::MODE_GAME;
                    try_chg = 1'b1;
                end
                else
                begin
                    tgt        = smc_pkg::MODE_GAME;
                    force_fail = 1'b1;
                end
            end
            smc_pkg::KIND_ACTIVITY:
            begin
                tsa_base = '0;
            end
            default:
            begin
                tgt = mode_reg;
            end
        endcase
    end

    // outputs: result of this step and the state it leaves
    always_comb
    begin
        ok     = try_chg && smc_pkg::allowed(mode_reg, tgt);
        last_v = !(is_peer && ok && tgt != smc_pkg::MODE_GAME);

        mode_next   = ok ? tgt : mode_reg;
        origin_next = (ok && tgt == smc_pkg::MODE_GAME) ? mode_reg : origin_reg;
        tim_next    = ok ? '0 : tim_base;
        tsa_next    = ok ? '0 : tsa_base;
        mask_next   = ok ? smc_pkg::merge_mask(mask_base, tgt) : mask_base;
        tim_sat_cmp = CW'(tim_next);

        res.accepted     = try_chg ? ok : !force_fail;
        res.changed      = ok;
        res.from_mode    = mode_reg;
        res.to_mode      = tgt;
        res.cause        = cause_v;
        res.mask         = mask_next;
        res.time_in_mode = (tim_sat_cmp > CW'(smc_pkg::TIME_OUT_MAX)) ?
                           smc_pkg::TIME_OUT_MAX : tim_sat_cmp[smc_pkg::TIME_OUT_W-1:0];
        res.last         = last_v;

        res_push = step;
        cmd_pop  = step && last_v;
    end

    // next peer chain step
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            if (last_v)
            begin
                phase_next = smc_pkg::PH_FIRST;
            end
            else if (tgt == smc_pkg::MODE_IDLE)
            begin
                phase_next = smc_pkg::PH_SECOND;
            end
            else
            begin
                phase_next = smc_pkg::PH_THIRD;
            end
        end
    end

    // mode state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= smc_pkg::MODE_BOOTING;
            origin_reg <= smc_pkg::MODE_BOOTING;
            tim_reg    <= '0;
            tsa_reg    <= '0;
            phase_reg  <= smc_pkg::PH_FIRST;
        end
        else
        begin
            phase_reg <= phase_next;
            if (step)
            begin
                mode_reg   <= mode_next;
                origin_reg <= origin_next;
                tim_reg    <= tim_next;
                tsa_reg    <= tsa_next;
            end
        end
    end

    // running feature mask within a peer chain
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            mask_reg <= mask_next;
        end
    end

    // a command leaves the queue only with its final result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (res_push && res.last))
    else $error("command popped without its final result");

    // a reported change is the mode held afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.changed) |=> (mode_reg == $past(res.to_mode)))
    else $error("mode does not follow the reported change");

    // every change restarts both counters
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.changed) |=> (tim_reg == '0 && tsa_reg == '0))
    else $error("counters not cleared on a mode change");

    // a chain stays open after a result that is not final
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res.last) |=> (phase_reg != smc_pkg::PH_FIRST))
    else $error("peer chain closed before its final result");

endmodule

>>> hw/rtl/system_mode_controller.sv
// system_mode_controller: six-mode system controller, top level
// path: a transaction waits in the command queue and its result in the result queue before the output ports
// throughput: one transaction per cycle while neither queue is full; a peer game request makes one mode
// change per step, up to three, carried out by the single-step executor in the back part
// reset: rst_n clears mode, counters and queues and reloads the default timeouts at once
// depends on smc_pkg, smc_regs, smc_front, smc_back and smc_fifo
module system_mode_controller #(
    parameter int TICK_COUNTER_BITS = smc_pkg::TICK_COUNTER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input queue side
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      mode,
    input  logic [smc_pkg::MODE_W-1:0]      target_mode,
    input  logic [smc_pkg::MASK_W-1:0]      feature_mask_in,
    // result queue side
    output logic                            empty,
    input  logic                            pop,
    output logic                            accepted,
    output logic                            changed,
    output logic [smc_pkg::MODE_W-1:0]      from_mode,
    output logic [smc_pkg::MODE_W-1:0]      to_mode,
    output logic [1:0]                      cause,
    output logic [smc_pkg::MASK_W-1:0]      feature_mask_out,
    output logic [smc_pkg::TIME_OUT_W-1:0]  time_in_mode,
    output logic                            last,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [smc_pkg::PADDR_W-1:0]     paddr,
    input  logic [smc_pkg::PDATA_W-1:0]     pwdata,
    output logic [smc_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    smc_pkg::cfg_t    cfg;
    smc_pkg::cmd_t    cmd;
    logic             cmd_valid;
    logic             cmd_pop;
    logic             res_full;
    logic             res_push;
    smc_pkg::result_t res_in;
    smc_pkg::result_t res_out;

    // configuration registers
    smc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front: accept and classify
    smc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .mode            (mode),
        .target_mode     (target_mode),
        .feature_mask_in (feature_mask_in),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop)
    );

    // back: carry out mode changes
    smc_back #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue
    smc_fifo #(
        .WIDTH ($bits(smc_pkg::result_t)),
        .DEPTH (smc_pkg::RES_FIFO_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    // result fields to ports
    assign accepted         = res_out.accepted;
    assign changed          = res_out.changed;
    assign from_mode        = res_out.from_mode;
    assign to_mode          = res_out.to_mode;
    assign cause            = res_out.cause;
    assign feature_mask_out = res_out.mask;
    assign time_in_mode     = res_out.time_in_mode;
    assign last             = res_out.last;

endmodule
